>>> src/aligned_stack_allocator_macros.svh
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef ALIGNED_STACK_ALLOCATOR_MACROS_SVH
`define ALIGNED_STACK_ALLOCATOR_MACROS_SVH

// condition that holds on every edge
`define ASA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence that must hold on the same edge as the antecedent
`define ASA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/asa_pkg.sv
package asa_pkg;

  localparam int DEF_MAX_BLOCKS    = 64;
  localparam int HEADER_BYTES      = 40;
  localparam int NODE_HEADER_BYTES = 16;
  // must be a power of two
  localparam int WORD_BYTES        = 8;

  localparam int HDR_RND = ((HEADER_BYTES + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;

  localparam int DATA_W     = 32;
  localparam int ALIGN_W    = 17;
  localparam int BLK_ADDR_W = 33;
  localparam int PAD_W      = 18;
  localparam int PADDR_W    = 3;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOMEM    = 3'd2;
  localparam logic [2:0] ST_BADALIGN = 3'd3;
  localparam logic [2:0] ST_BOUNDS   = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_SIZE = 1'b1;

  typedef struct packed {
    logic [BLK_ADDR_W-1:0] addr;
    logic [PAD_W-1:0]      pad;
  } blk_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    blk_entry_t entry;
  } stack_op_t;

endpackage

>>> src/aligned_stack_allocator.sv
// aligned LIFO stack allocator
// a request beat goes into an input register, then into the result register when not stalled
// throughput: one request per cycle without rsp_stall, set by updating top, peak and stack head
// block list is a memory read two entries below the head every cycle, so pops keep full rate
// rst: base 0, region 65536, top and peak 40, no live blocks, no clearing pass
module aligned_stack_allocator
  import asa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         kind,
  input  logic [DATA_W-1:0]  request_size,
  input  logic [ALIGN_W-1:0] alignment,
  input  logic [DATA_W-1:0]  block_address,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [2:0]         status,
  output logic [DATA_W-1:0]  granted_address,
  output logic [DATA_W-1:0]  used_bytes,
  output logic [DATA_W-1:0]  peak_bytes,
  output logic [CNT_W-1:0]   live_blocks
);

`include "aligned_stack_allocator_macros.svh"

  logic [DATA_W-1:0]  base_address;
  logic [DATA_W-1:0]  region_size;

  logic               held;
  logic [1:0]         kind_q;
  logic [DATA_W-1:0]  size_q;
  logic [ALIGN_W-1:0] align_q;
  logic [DATA_W-1:0]  addr_q;

  logic [DATA_W-1:0]  top;
  logic [DATA_W-1:0]  peak;
  logic [CNT_W-1:0]   count;
  blk_entry_t         head;

  logic               advance;
  logic               fire;
  logic               accept;
  logic [2:0]         status_next;
  logic [DATA_W-1:0]  granted_next;
  logic [DATA_W-1:0]  top_next;
  logic [DATA_W-1:0]  peak_next;
  stack_op_t          step_op;
  stack_op_t          op;

  asa_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .base_address (base_address),
    .region_size  (region_size)
  );

  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = held && advance;
  assign req_stall = held && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!req_stall) begin
      held <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q  <= kind;
      size_q  <= request_size;
      align_q <= alignment;
      addr_q  <= block_address;
    end
  end

  asa_step #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CNT_W      (CNT_W)
  ) u_step (
    .kind          (kind_q),
    .request_size  (size_q),
    .alignment     (align_q),
    .block_address (addr_q),
    .base_address  (base_address),
    .region_size   (region_size),
    .top           (top),
    .peak          (peak),
    .count         (count),
    .head          (head),
    .status        (status_next),
    .granted       (granted_next),
    .top_next      (top_next),
    .peak_next     (peak_next),
    .op            (step_op)
  );

  always_comb begin
    op       = step_op;
    op.push  = step_op.push && fire;
    op.pop   = step_op.pop && fire;
    op.clear = step_op.clear && fire;
  end

  asa_block_stack #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CNT_W      (CNT_W)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .count (count),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top  <= DATA_W'(HDR_RND);
      peak <= DATA_W'(HDR_RND);
    end else if (fire) begin
      top  <= top_next;
      peak <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // result beat carries the count after the update
  always_ff @(posedge clk) begin
    if (fire) begin
      status          <= status_next;
      granted_address <= granted_next;
      used_bytes      <= top_next;
      peak_bytes      <= peak_next;
      live_blocks     <= op.clear ? '0 :
                         op.push  ? count + CNT_W'(1) :
                         op.pop   ? count - CNT_W'(1) : count;
    end
  end

  `ASA_ASSERT_ALWAYS(top_below_peak, top <= peak, "top above peak")
  `ASA_ASSERT_IMPLY(no_grant_on_error, rsp_valid && (status != ST_OK), granted_address == '0,
    "address granted on failed request")
  `ASA_ASSERT_IMPLY(live_matches_stack, rsp_valid && !held, live_blocks == count,
    "live block count out of step with stack")

endmodule

>>> src/asa_apb_regs.sv
module asa_apb_regs
  import asa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output logic [DATA_W-1:0]   base_address,
  output logic [DATA_W-1:0]   region_size
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      region_size  <= DATA_W'(65536);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_BASE: base_address <= pwdata;
        REG_SIZE: region_size  <= pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BASE: prdata = base_address;
      REG_SIZE: prdata = region_size;
      default:  prdata = '0;
    endcase
  end

endmodule

>>> src/asa_step.sv
module asa_step
  import asa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic [1:0]         kind,
  input  logic [DATA_W-1:0]  request_size,
  input  logic [ALIGN_W-1:0] alignment,
  input  logic [DATA_W-1:0]  block_address,
  input  logic [DATA_W-1:0]  base_address,
  input  logic [DATA_W-1:0]  region_size,
  input  logic [DATA_W-1:0]  top,
  input  logic [DATA_W-1:0]  peak,
  input  logic [CNT_W-1:0]   count,
  input  blk_entry_t         head,
  output logic [2:0]         status,
  output logic [DATA_W-1:0]  granted,
  output logic [DATA_W-1:0]  top_next,
  output logic [DATA_W-1:0]  peak_next,
  output stack_op_t          op
);

  logic [ALIGN_W-1:0]    amask;
  logic                  align_ok;
  logic [BLK_ADDR_W-1:0] cur;
  logic [ALIGN_W-1:0]    pad0;
  logic [PAD_W-1:0]      node_rnd;
  logic [PAD_W-1:0]      pad;
  logic [DATA_W+1:0]     need;
  logic                  full;
  logic [BLK_ADDR_W-1:0] at;
  logic [BLK_ADDR_W-1:0] limit;
  logic [DATA_W-1:0]     rel;
  logic [DATA_W-1:0]     init_off;

  always_comb begin
    amask    = alignment - ALIGN_W'(1);
    align_ok = (alignment != '0) && ((alignment & amask) == '0);
    cur      = {1'b0, base_address} + {1'b0, top};
    pad0     = (ALIGN_W'(~cur[ALIGN_W-1:0]) + ALIGN_W'(1)) & amask;
    node_rnd = (PAD_W'(NODE_HEADER_BYTES) + PAD_W'(alignment) - PAD_W'(1)) & ~PAD_W'(amask);
    pad      = (PAD_W'(pad0) < PAD_W'(NODE_HEADER_BYTES)) ? PAD_W'(pad0) + node_rnd
                                                          : PAD_W'(pad0);
    need     = (DATA_W+2)'(top) + (DATA_W+2)'(pad) + (DATA_W+2)'(request_size);
    full     = count >= CNT_W'(MAX_BLOCKS);
    at       = cur + BLK_ADDR_W'(pad);
    limit    = {1'b0, base_address} + {1'b0, region_size};
    rel      = block_address - base_address;
    init_off = ((~base_address + DATA_W'(1)) & DATA_W'(WORD_BYTES - 1)) + DATA_W'(HDR_RND);

    status      = ST_OK;
    granted     = '0;
    top_next    = top;
    peak_next   = peak;
    op.push     = 1'b0;
    op.pop      = 1'b0;
    op.clear    = 1'b0;
    op.entry    = '{addr: at, pad: pad};

    unique case (kind)
      KIND_ALLOC: begin
        if (!align_ok) begin
          status = ST_BADALIGN;
        end else if ((need > (DATA_W+2)'(region_size)) || full) begin
          status = ST_NOMEM;
        end else begin
          top_next  = need[DATA_W-1:0];
          peak_next = (need[DATA_W-1:0] > peak) ? need[DATA_W-1:0] : peak;
          granted   = at[DATA_W-1:0];
          op.push   = 1'b1;
        end
      end
      KIND_FREE: begin
        if (block_address == '0) begin
          status = ST_INVALID;
        end else if ((block_address < base_address) || ({1'b0, block_address} >= limit)) begin
          status = ST_BOUNDS;
        end else if ({1'b0, block_address} >= cur) begin
          status = ST_IGNORED;
        end else if ((count == '0) || (head.addr != {1'b0, block_address})) begin
          status = ST_BOUNDS;
        end else begin
          top_next = (rel >= DATA_W'(head.pad)) ? rel - DATA_W'(head.pad) : '0;
          op.pop   = 1'b1;
        end
      end
      KIND_RESET: begin
        top_next  = init_off;
        peak_next = init_off;
        op.clear  = 1'b1;
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

endmodule

>>> src/asa_block_stack.sv
module asa_block_stack
  import asa_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
  parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  stack_op_t         op,
  output logic [CNT_W-1:0]  count,
  output blk_entry_t        head
);

`include "aligned_stack_allocator_macros.svh"

  blk_entry_t mem [MAX_BLOCKS];
  blk_entry_t rd;
  blk_entry_t sec;
  logic       sec_sel;
  blk_entry_t second;
  logic [CNT_W-1:0] cnt_m3;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  // entry below the head comes from the read port right after a pop
  assign second = sec_sel ? rd : sec;
  assign cnt_m3 = count - CNT_W'(3);
  assign rd_idx = IDX_W'(cnt_m3);
  assign wr_idx = IDX_W'(count);

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[wr_idx] <= op.entry;
    end
    rd <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sec_sel <= 1'b0;
    end else begin
      priority if (op.clear) begin
        count   <= '0;
        sec_sel <= 1'b0;
      end else if (op.push) begin
        count   <= count + CNT_W'(1);
        sec_sel <= 1'b0;
      end else if (op.pop) begin
        count   <= count - CNT_W'(1);
        sec_sel <= 1'b1;
      end else begin
        sec_sel <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      head <= op.entry;
      sec  <= head;
    end else if (op.pop) begin
      head <= second;
    end else begin
      sec  <= second;
    end
  end

  `ASA_ASSERT_ALWAYS(op_exclusive, $onehot0({op.push, op.pop, op.clear}), "stack ops overlap")
  `ASA_ASSERT_IMPLY(push_has_room, op.push, count < CNT_W'(MAX_BLOCKS), "push on full stack")
  `ASA_ASSERT_IMPLY(pop_not_empty, op.pop, count != '0, "pop on empty stack")

endmodule
